/* sv/mkvpf_pkg.sv */
package mkvpf_pkg;

	// fixed field widths of the request, result and configuration channels
	localparam int TYPE_W = 2;
	localparam int PROC_W = 4;
	localparam int PAGE_W = 6;
	localparam int CONF_W = 7;

	localparam int PCT_SCALE = 100;
	localparam int MAX_PICKS = 3;
	localparam logic [CONF_W-1:0] CONF_RESET = 7'd20;

	// request type codes
	localparam logic [TYPE_W-1:0] REQ_RECORD  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_BY_PROC = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_BY_PAGE = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_REC_LP,
		ST_REC_WR,
		ST_SRC_LP,
		ST_SCAN,
		ST_DRAIN,
		ST_THR,
		ST_QUAL,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic req_load;
		logic lp_write;
		logic cnt_write;
		logic src_page;
		logic src_lp;
		logic best_clr;
		logic scan;
		logic thr_load;
		logic qual_step;
		logic pk_inc;
		logic pk_clr;
		logic emit;
		logic clr_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic proc_ok;
		logic page_ok;
		logic lp_valid;
		logic col_last;
		logic pk_last;
		logic clr_done;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

/* sv/mkvpf_ctrl.sv */
module mkvpf_ctrl import mkvpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register, clearing pass runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.best_clr = 1'b1;
				unique case (sts.req_type)
					REQ_RECORD: begin
						if (sts.proc_ok && sts.page_ok) begin
							state_d = ST_REC_LP;
						end else begin
							state_d = ST_IDLE;
						end
					end
					REQ_BY_PROC: begin
						if (sts.proc_ok && sts.lp_valid) begin
							state_d = ST_SRC_LP;
						end else begin
							state_d = ST_EMIT;
						end
					end
					REQ_BY_PAGE: begin
						if (sts.page_ok) begin
							cmd.src_page = 1'b1;
							state_d      = ST_SCAN;
						end else begin
							state_d = ST_EMIT;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_REC_LP: begin
				// no previous page: only the last page is stored
				if (sts.lp_valid) begin
					state_d = ST_REC_WR;
				end else begin
					cmd.lp_write = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_REC_WR: begin
				cmd.cnt_write = 1'b1;
				cmd.lp_write  = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_SRC_LP: begin
				cmd.src_lp = 1'b1;
				state_d    = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.col_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_THR;
			end
			ST_THR: begin
				cmd.thr_load = 1'b1;
				state_d      = ST_QUAL;
			end
			ST_QUAL: begin
				cmd.qual_step = 1'b1;
				if (sts.pk_last) begin
					cmd.pk_clr = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.pk_inc = 1'b1;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.pk_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// an accepted request is always decoded next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_DECODE)
		else $error("accepted request not decoded");

	// the final result of a query returns the block to idle
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && sts.out_free && sts.emit_last |=> state_q == ST_IDLE)
		else $error("query did not finish after last result");

	// a result is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded into a full output register");

endmodule

/* sv/mkvpf_dpath.sv */
module mkvpf_dpath import mkvpf_pkg::*; #(
	parameter int NUM_PAGES     = 64,
	parameter int NUM_PROCESSES = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [PROC_W-1:0] proc_id,
	input  logic [PAGE_W-1:0] page_id,
	input  logic              cfg_we,
	input  logic [CONF_W-1:0] cfg_data,
	input  logic              out_stall,
	output logic              out_valid,
	output logic              has_prediction,
	output logic [PAGE_W-1:0] predicted_page,
	output logic              last
);

	localparam int PW = $clog2(NUM_PAGES);
	localparam int QW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int AW = 2 * PW;
	localparam int CW = COUNT_WIDTH;
	localparam int TW = CW + PW;
	localparam int MW = TW + CONF_W;
	localparam logic [PW-1:0] LAST_COL = PW'(NUM_PAGES - 1);
	localparam logic [1:0]    LAST_PK  = 2'(MAX_PICKS - 1);

	logic [TYPE_W-1:0] req_type_q;
	logic [PROC_W-1:0] req_proc_q;
	logic [PAGE_W-1:0] req_page_q;
	logic [CONF_W-1:0] conf_q;
	logic [QW-1:0]     proc_idx;
	logic [PW-1:0]     page_idx;

	logic [PW-1:0]            lp_mem [NUM_PROCESSES];
	logic [PW-1:0]            lp_rd_q;
	logic [NUM_PROCESSES-1:0] lv_q;

	logic [CW-1:0] cnt_mem [2**AW];
	logic [CW-1:0] cnt_rd_q;
	logic [CW-1:0] cnt_inc;
	logic [AW-1:0] rec_addr;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] clr_q;

	logic [PW-1:0] src_q;
	logic [PW-1:0] col_q;
	logic [PW-1:0] col_s1;
	logic          scan_v_s1;

	logic [TW-1:0] total_q;
	logic [CW-1:0] best_cnt_q [MAX_PICKS];
	logic [PW-1:0] best_pg_q  [MAX_PICKS];
	logic [MW-1:0] thr_q;
	logic [MW-1:0] scaled;
	logic [CW-1:0] sel_cnt;
	logic [MAX_PICKS-1:0] qual_q;
	logic [1:0]    pk_q;
	logic [1:0]    pick_n;
	logic          emit_last;

	logic              out_valid_q;
	logic              has_q;
	logic [PAGE_W-1:0] page_q;
	logic              last_q;

	// request and threshold registers
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_type_q <= req_type;
			req_proc_q <= proc_id;
			req_page_q <= page_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q <= CONF_RESET;
		end else if (cfg_we) begin
			conf_q <= cfg_data;
		end
	end

	assign proc_idx = QW'(req_proc_q);
	assign page_idx = PW'(req_page_q);

	// last page store per process
	always_ff @(posedge clk) begin
		if (cmd.lp_write) begin
			lp_mem[proc_idx] <= page_idx;
		end
		lp_rd_q <= lp_mem[proc_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '0;
		end else if (cmd.lp_write) begin
			lv_q[proc_idx] <= 1'b1;
		end
	end

	// transition count store, cleared by a sweep after reset
	assign rec_addr = {lp_rd_q, page_idx};
	assign rd_addr  = cmd.scan ? {src_q, col_q} : rec_addr;
	assign cnt_inc  = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			cnt_mem[clr_q] <= '0;
		end else if (cmd.cnt_write) begin
			cnt_mem[rec_addr] <= cnt_inc;
		end
		cnt_rd_q <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// source row and column counter
	always_ff @(posedge clk) begin
		if (cmd.src_page) begin
			src_q <= page_idx;
		end else if (cmd.src_lp) begin
			src_q <= lp_rd_q;
		end
		if (cmd.best_clr) begin
			col_q <= '0;
		end else if (cmd.scan) begin
			col_q <= col_q + 1'b1;
		end
		col_s1 <= col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= cmd.scan;
		end
	end

	// row total and top three insert, one counter per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < MAX_PICKS; i++) begin
				best_cnt_q[i] <= '0;
				best_pg_q[i]  <= '0;
			end
		end else if (cmd.best_clr) begin
			total_q <= '0;
			for (int i = 0; i < MAX_PICKS; i++) begin
				best_cnt_q[i] <= '0;
				best_pg_q[i]  <= '0;
			end
		end else if (scan_v_s1 && cnt_rd_q != '0) begin
			total_q <= total_q + TW'(cnt_rd_q);
			// strict compare keeps the lower page ahead on equal counts
			if (cnt_rd_q > best_cnt_q[0]) begin
				best_cnt_q[2] <= best_cnt_q[1];
				best_pg_q[2]  <= best_pg_q[1];
				best_cnt_q[1] <= best_cnt_q[0];
				best_pg_q[1]  <= best_pg_q[0];
				best_cnt_q[0] <= cnt_rd_q;
				best_pg_q[0]  <= col_s1;
			end else if (cnt_rd_q > best_cnt_q[1]) begin
				best_cnt_q[2] <= best_cnt_q[1];
				best_pg_q[2]  <= best_pg_q[1];
				best_cnt_q[1] <= cnt_rd_q;
				best_pg_q[1]  <= col_s1;
			end else if (cnt_rd_q > best_cnt_q[2]) begin
				best_cnt_q[2] <= cnt_rd_q;
				best_pg_q[2]  <= col_s1;
			end
		end
	end

	// share test: count*100 >= min_conf*total
	always_ff @(posedge clk) begin
		if (cmd.thr_load) begin
			thr_q <= MW'(conf_q) * MW'(total_q);
		end
	end

	assign sel_cnt = best_cnt_q[pk_q];
	assign scaled  = MW'(sel_cnt) * MW'(PCT_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qual_q <= '0;
			pk_q   <= '0;
		end else begin
			if (cmd.best_clr) begin
				qual_q <= '0;
			end else if (cmd.qual_step) begin
				qual_q[pk_q] <= (sel_cnt != '0) && (scaled >= thr_q);
			end
			if (cmd.best_clr || cmd.pk_clr) begin
				pk_q <= '0;
			end else if (cmd.pk_inc) begin
				pk_q <= pk_q + 2'd1;
			end
		end
	end

	// qualified picks form a prefix since counts are sorted
	assign pick_n    = 2'($countones(qual_q));
	assign emit_last = (pick_n == 2'd0) || (pk_q == pick_n - 2'd1);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			has_q  <= (pick_n != 2'd0);
			page_q <= (pick_n != 2'd0) ? PAGE_W'(best_pg_q[pk_q]) : '0;
			last_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign has_prediction = has_q;
	assign predicted_page = page_q;
	assign last           = last_q;

	// status to controller
	always_comb begin
		sts           = '0;
		sts.req_type  = req_type_q;
		sts.proc_ok   = (int'(req_proc_q) < NUM_PROCESSES);
		sts.page_ok   = (int'(req_page_q) < NUM_PAGES);
		sts.lp_valid  = lv_q[proc_idx];
		sts.col_last  = (col_q == LAST_COL);
		sts.pk_last   = (pk_q == LAST_PK);
		sts.clr_done  = (clr_q == '1);
		sts.out_free  = !out_valid_q || !out_stall;
		sts.emit_last = emit_last;
	end

	// top three stay sorted by count
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		best_cnt_q[0] >= best_cnt_q[1] && best_cnt_q[1] >= best_cnt_q[2])
		else $error("top three counts out of order");

	// qualified picks are a prefix of the sorted list
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(!qual_q[1] || qual_q[0]) && (!qual_q[2] || qual_q[1]))
		else $error("qualified picks not a prefix");

	// an empty answer is always the final result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !has_q |-> last_q)
		else $error("empty answer without last");

endmodule

/* sv/markov_page_prefetch_predictor_unit.sv */
// markov page prefetcher, one request at a time
// record: last page read, count read, then count and last page write before the next accept
// query: a by-process query first loads its row from the last page store, a by-page query does not;
//   the row is read one counter per cycle, then one result per unstalled cycle
// empty answer with no scan: decode, then emit; reset: threshold 20, last pages invalid, the count
//   store's 2**(2*clog2(NUM_PAGES)) entries (4096) are swept clear before the first request
module markov_page_prefetch_predictor_unit import mkvpf_pkg::*; #(
	parameter int NUM_PAGES     = 64,
	parameter int NUM_PROCESSES = 16,
	parameter int COUNT_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [PROC_W-1:0] proc_id,
	input  logic [PAGE_W-1:0] page_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              has_prediction,
	output logic [PAGE_W-1:0] predicted_page,
	output logic              last,
	input  logic              cfg_we,
	input  logic [CONF_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	mkvpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stores, scan and result logic
	mkvpf_dpath #(
		.NUM_PAGES     (NUM_PAGES),
		.NUM_PROCESSES (NUM_PROCESSES),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.proc_id        (proc_id),
		.page_id        (page_id),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.has_prediction (has_prediction),
		.predicted_page (predicted_page),
		.last           (last)
	);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import mkvpf_pkg::*;

	localparam int NUM_PG      = 64;
	localparam int NUM_PROC    = 16;
	localparam int CNT_W       = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;
	// a query scans one full row, so the settle wait is sized from the row length
	localparam int SETTLE_CYC  = 2 * NUM_PG + 40;
	localparam int HOLD_CYC    = 600;
	localparam int RUN_RECORDS = 20;
	localparam int PHASE_ITEMS = 52;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [TYPE_W-1:0] kind;
		logic [PROC_W-1:0] proc;
		logic [PAGE_W-1:0] page;
		logic              tight;
	} req_t;

	typedef struct packed {
		logic              has;
		logic [PAGE_W-1:0] page;
		logic              fin;
	} hint_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [TYPE_W-1:0] req_type = '0;
	logic [PROC_W-1:0] proc_id = '0;
	logic [PAGE_W-1:0] page_id = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              has_prediction;
	logic [PAGE_W-1:0] predicted_page;
	logic              res_last;
	logic              cfg_we = 1'b0;
	logic [CONF_W-1:0] cfg_data = '0;

	// mirror of the transition counts and per-process history
	bit [CNT_W-1:0]    trans_cnt [NUM_PG][NUM_PG];
	bit [PAGE_W-1:0]   hist_page [NUM_PROC];
	bit                prev_ok [NUM_PROC];
	logic [CONF_W-1:0] min_conf = CONF_RESET;

	req_t  pending_q [$];
	hint_t hint_q [$];
	req_t  next_req;
	hint_t want;

	int    mismatch_cnt = 0;
	int    n_req = 0;
	int    n_query = 0;
	int    n_hint = 0;
	int    cycle_cnt = 0;
	int    gap_left = 0;
	int    burst_left = 1;
	int    hold_left = 0;
	bit [31:0] stall_tick = '0;
	bit    calm = 1'b0;
	bit    hold_go = 1'b0;
	bit    hold_seen = 1'b0;

	markov_page_prefetch_predictor_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.proc_id       (proc_id),
		.page_id       (page_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_prediction(has_prediction),
		.predicted_page(predicted_page),
		.last          (res_last),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// count one transition, saturating, then move the process to the new page
	function automatic void note_access(input logic [PROC_W-1:0] proc,
			input logic [PAGE_W-1:0] page);
		if (prev_ok[proc] && trans_cnt[hist_page[proc]][page] != CNT_MAX)
			trans_cnt[hist_page[proc]][page]++;
		hist_page[proc] = page;
		prev_ok[proc] = 1'b1;
	endfunction

	// top three successors of a row, most frequent first, then the share filter
	function automatic void rank_successors(input bit src_ok, input logic [PAGE_W-1:0] src);
		int unsigned total;
		int unsigned cnt;
		int unsigned top_cnt [MAX_PICKS];
		int unsigned top_pg [MAX_PICKS];
		int unsigned keep_pg [MAX_PICKS];
		int          n_top;
		int          n_keep;
		int          pos;
		hint_t       h;
		total = 0;
		n_top = 0;
		n_keep = 0;
		if (src_ok) begin
			for (int p = 0; p < NUM_PG; p++) begin
				cnt = 32'(trans_cnt[src][p]);
				if (cnt != 0) begin
					total += cnt;
					// first slot holding a strictly smaller count; ties keep the lower page
					pos = n_top;
					for (int i = n_top - 1; i >= 0; i--)
						if (cnt > top_cnt[i])
							pos = i;
					if (pos < MAX_PICKS) begin
						if (n_top < MAX_PICKS)
							n_top++;
						for (int j = n_top - 1; j > pos; j--) begin
							top_cnt[j] = top_cnt[j-1];
							top_pg[j] = top_pg[j-1];
						end
						top_cnt[pos] = cnt;
						top_pg[pos] = p;
					end
				end
			end
			for (int i = 0; i < n_top; i++)
				if ((top_cnt[i] * PCT_SCALE) / total >= 32'(min_conf)) begin
					keep_pg[n_keep] = top_pg[i];
					n_keep++;
				end
		end
		if (n_keep == 0) begin
			h.has = 1'b0;
			h.page = '0;
			h.fin = 1'b1;
			hint_q.insert(hint_q.size(), h);
		end else begin
			for (int i = 0; i < n_keep; i++) begin
				h.has = 1'b1;
				h.page = PAGE_W'(keep_pg[i]);
				h.fin = (i == n_keep - 1);
				hint_q.insert(hint_q.size(), h);
			end
		end
	endfunction

	function automatic void add_req(input logic [TYPE_W-1:0] kind,
			input logic [PROC_W-1:0] proc, input logic [PAGE_W-1:0] page,
			input logic tight = 1'b0);
		req_t r;
		r.kind = kind;
		r.proc = proc;
		r.page = page;
		r.tight = tight;
		pending_q.insert(pending_q.size(), r);
	endfunction

	// mostly records over a few hot pages so rows build up real histories
	function automatic req_t random_req();
		req_t r;
		int   roll;
		roll = $urandom_range(0, 99);
		if (roll < 58)
			r.kind = REQ_RECORD;
		else if (roll < 78)
			r.kind = REQ_BY_PROC;
		else if (roll < 95)
			r.kind = REQ_BY_PAGE;
		else
			r.kind = REQ_NONE;
		if ($urandom_range(0, 9) < 7)
			r.proc = PROC_W'($urandom_range(0, 3));
		else
			r.proc = PROC_W'($urandom_range(0, NUM_PROC - 1));
		roll = $urandom_range(0, 9);
		if (roll < 4)
			r.page = PAGE_W'($urandom_range(0, 3));
		else if (roll < 7)
			r.page = PAGE_W'($urandom_range(NUM_PG - 4, NUM_PG - 1));
		else
			r.page = PAGE_W'($urandom_range(0, NUM_PG - 1));
		r.tight = 1'b0;
		return r;
	endfunction

	// block is idle once nothing is queued, offered or owed
	task automatic settle();
		while (pending_q.size() != 0 || in_valid || hint_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_min_conf(input logic [CONF_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_conf = v;
	endtask

	task automatic random_phase(input logic [CONF_W-1:0] conf, input bit quiet,
			input bit with_hold);
		set_min_conf(conf);
		calm <= quiet;
		if (with_hold)
			hold_go <= ~hold_go;
		repeat (PHASE_ITEMS) pending_q.insert(pending_q.size(), random_req());
		settle();
	endtask

	// stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty answers, tie order, three-result cap, ignored type
		add_req(REQ_BY_PROC, 4'd0, 6'd0);
		add_req(REQ_BY_PAGE, 4'd0, 6'd0);
		add_req(REQ_RECORD, 4'd0, 6'd5);
		add_req(REQ_RECORD, 4'd0, 6'd6);
		add_req(REQ_RECORD, 4'd0, 6'd5);
		add_req(REQ_RECORD, 4'd0, 6'd7);
		add_req(REQ_RECORD, 4'd0, 6'd5);
		add_req(REQ_RECORD, 4'd0, 6'd6);
		add_req(REQ_RECORD, 4'd1, 6'd5);
		add_req(REQ_RECORD, 4'd1, 6'd8);
		add_req(REQ_RECORD, 4'd1, 6'd5);
		add_req(REQ_RECORD, 4'd1, 6'd9);
		add_req(REQ_BY_PAGE, 4'd0, 6'd5);
		add_req(REQ_BY_PROC, 4'd0, 6'd63);
		add_req(REQ_NONE, 4'd0, 6'd63);
		add_req(REQ_BY_PROC, 4'd0, 6'd0);
		add_req(REQ_RECORD, 4'd15, 6'd63);
		add_req(REQ_RECORD, 4'd15, 6'd0);
		add_req(REQ_BY_PAGE, 4'd15, 6'd63);
		add_req(REQ_BY_PROC, 4'd15, 6'd42);
		add_req(REQ_RECORD, 4'd15, 6'd0);
		add_req(REQ_BY_PROC, 4'd15, 6'd21);
		add_req(REQ_BY_PAGE, 4'd9, 6'd1);
		settle();

		// random phases over a spread of thresholds
		random_phase(7'd0, 1'b0, 1'b0);
		random_phase(7'd100, 1'b0, 1'b0);
		random_phase(7'd127, 1'b0, 1'b0);
		random_phase(7'd5, 1'b0, 1'b0);
		random_phase(CONF_W'($urandom_range(1, 99)), 1'b0, 1'b0);
		random_phase(7'd50, 1'b1, 1'b0);
		random_phase(7'd20, 1'b0, 1'b1);
		random_phase(7'd34, 1'b0, 1'b0);

		// back-to-back run of records on one self transition
		set_min_conf(7'd90);
		calm <= 1'b1;
		repeat (RUN_RECORDS) add_req(REQ_RECORD, 4'd15, 6'd63, 1'b1);
		add_req(REQ_BY_PAGE, 4'd0, 6'd63);
		add_req(REQ_BY_PROC, 4'd15, 6'd0);
		settle();
		set_min_conf(7'd0);
		calm <= 1'b0;
		add_req(REQ_RECORD, 4'd15, 6'd63);
		add_req(REQ_RECORD, 4'd15, 6'd63);
		add_req(REQ_BY_PAGE, 4'd0, 6'd63);
		add_req(REQ_RECORD, 4'd15, 6'd62);
		add_req(REQ_BY_PAGE, 4'd3, 6'd63);
		add_req(REQ_BY_PROC, 4'd15, 6'd63);
		settle();

		if (hint_q.size() != 0) begin
			mismatch_cnt++;
			$display("%0t: %0d results never arrived", $time, hint_q.size());
		end
		$display("run: %0d requests (%0d queries), %0d results checked", n_req, n_query, n_hint);
		$display("run: thresholds 0..127, back-to-back records, long output hold-off");
		if (mismatch_cnt == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// request driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && (gap_left == 0 || pending_q[0].tight)) begin
					next_req = pending_q.pop_front();
					in_valid <= 1'b1;
					req_type <= next_req.kind;
					proc_id <= next_req.proc;
					page_id <= next_req.page;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						if (calm || $urandom_range(0, 3) == 0)
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 20);
					end
				end else begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// result stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		stall_tick++;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = HOLD_CYC;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			case (stall_tick[8:6]) inside
				3'd0, 3'd1: out_stall <= 1'b0;
				3'd2: out_stall <= ($urandom_range(0, 3) == 0);
				3'd3: out_stall <= ($urandom_range(0, 3) != 0);
				3'd4: out_stall <= stall_tick[0];
				3'd5: out_stall <= (stall_tick[2:0] < 3'd5);
				default: out_stall <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			n_req++;
			case (req_type)
				REQ_RECORD: note_access(proc_id, page_id);
				REQ_BY_PROC: begin
					n_query++;
					rank_successors(prev_ok[proc_id], hist_page[proc_id]);
				end
				REQ_BY_PAGE: begin
					n_query++;
					rank_successors(1'b1, page_id);
				end
				default: ;
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			n_hint++;
			if (hint_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: result with none expected: has=%0b page=%0d last=%0b",
					$time, has_prediction, predicted_page, res_last);
			end else begin
				want = hint_q.pop_front();
				if (has_prediction !== want.has) begin
					mismatch_cnt++;
					$display("%0t: has_prediction expected %0b actual %0b",
						$time, want.has, has_prediction);
				end
				if (predicted_page !== want.page) begin
					mismatch_cnt++;
					$display("%0t: predicted_page expected %0d actual %0d",
						$time, want.page, predicted_page);
				end
				if (res_last !== want.fin) begin
					mismatch_cnt++;
					$display("%0t: last expected %0b actual %0b", $time, want.fin, res_last);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
			$display("tb_top failed");
			$finish;
		end
	end

endmodule

/* markov_page_prefetch_predictor_unit.f */
sv/mkvpf_pkg.sv
sv/mkvpf_ctrl.sv
sv/mkvpf_dpath.sv
sv/markov_page_prefetch_predictor_unit.sv
sim/tb_top.sv
